// ===== hdl/atp_pkg.sv =====
// Shared types, character codes and byte classification for the text pretokenizer.
`timescale 1ns / 1ps

package atp_pkg;

    // Byte classes of a run
    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_ALPHA = 3'd1;
    localparam logic [2:0] CLS_DIGIT = 3'd2;
    localparam logic [2:0] CLS_OTHER = 3'd3;
    localparam logic [2:0] CLS_SPACE = 3'd4;

    // Hold depth codes
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // Characters the contraction matcher looks for
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_S  = 8'h73;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_M  = 8'h6D;
    localparam logic [7:0] CH_LOW_D  = 8'h64;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_V  = 8'h76;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;
    localparam logic [7:0] CH_LOW_E  = 8'h65;

    // Input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       piece_start;
        logic       text_done;
    } t_out_beat;

    // Up to three released bytes caused by one input beat
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [2:0]      starts;
        logic [1:0]      cnt;
        logic            done;
    } t_group;

    // Outcome of running one byte through the run tracker
    typedef struct packed {
        logic       emit;
        logic       start;
        logic       hold;
        logic [2:0] run_class;
        logic       attached;
    } t_feed;

    function automatic logic [2:0] classify(input logic [7:0] b);
        logic [2:0] cls;
        if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
            cls = CLS_ALPHA;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            cls = CLS_DIGIT;
        end else if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D)) begin
            cls = CLS_SPACE;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    // Extend the current run, start a new piece, or hold an apostrophe
    function automatic t_feed feed_byte(input logic [7:0] b, input logic last,
                                        input logic [2:0] rc, input logic att);
        t_feed      f;
        logic [2:0] cls;
        cls         = classify(b);
        f.emit      = 1'b0;
        f.start     = 1'b0;
        f.hold      = 1'b0;
        f.run_class = rc;
        f.attached  = att;
        priority if (att) begin
            f.emit      = 1'b1;
            f.run_class = cls;
            f.attached  = 1'b0;
        end else if (rc != CLS_NONE && cls == rc) begin
            f.emit = 1'b1;
        end else if (b == CH_APOS && !last) begin
            f.hold = 1'b1;
        end else begin
            f.emit      = 1'b1;
            f.start     = 1'b1;
            f.run_class = cls;
            f.attached  = (b == CH_SPACE);
        end
        return f;
    endfunction

endpackage

// ===== hdl/atp_front.sv =====
// Front end: classifies each accepted byte, tracks runs and contractions, forms byte groups.
`timescale 1ns / 1ps

module atp_front
    import atp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    output t_group   o_group,
    output logic     o_group_valid
);

    logic [7:0] r_h0, n_h0;
    logic [7:0] r_h1, n_h1;
    logic [1:0] r_held_count, n_held_count;
    logic [2:0] r_run, n_run;
    logic       r_att, n_att;

    logic [7:0] b;
    logic       last;
    logic [2:0] rc_f;
    logic       att_f;
    logic [7:0] want;
    t_feed      f;
    t_group     grp;

    assign b    = i_beat.in_byte;
    assign last = i_beat.end_of_text;
    assign want = (r_h1 == CH_LOW_L) ? CH_LOW_L : CH_LOW_E;

    // Pick the run state the trailing byte is fed against
    always_comb begin
        unique case (r_held_count)
            HELD_ONE: begin
                rc_f  = CLS_OTHER;
                att_f = 1'b0;
            end
            HELD_TWO: begin
                rc_f  = CLS_ALPHA;
                att_f = 1'b0;
            end
            default: begin
                rc_f  = r_run;
                att_f = r_att;
            end
        endcase
    end

    assign f = feed_byte(b, last, rc_f, att_f);

    // Resolve held bytes and build the group of released bytes
    always_comb begin
        n_h0         = r_h0;
        n_h1         = r_h1;
        n_held_count = r_held_count;
        n_run        = r_run;
        n_att        = r_att;
        grp          = '0;
        unique case (r_held_count)
            HELD_ONE: begin
                if (b == CH_LOW_S || b == CH_LOW_T || b == CH_LOW_M || b == CH_LOW_D) begin
                    grp.bytes[0]  = r_h0;
                    grp.starts[0] = 1'b1;
                    grp.bytes[1]  = b;
                    grp.cnt       = 2'd2;
                    n_held_count  = HELD_NONE;
                    n_run         = CLS_NONE;
                end else if ((b == CH_LOW_R || b == CH_LOW_V || b == CH_LOW_L) && !last) begin
                    n_h1         = b;
                    n_held_count = HELD_TWO;
                end else begin
                    grp.bytes[0]  = r_h0;
                    grp.starts[0] = 1'b1;
                    grp.bytes[1]  = b;
                    grp.starts[1] = f.start;
                    grp.cnt       = f.emit ? 2'd2 : 2'd1;
                    n_held_count  = f.hold ? HELD_ONE : HELD_NONE;
                    n_h0          = f.hold ? b : r_h0;
                    n_run         = f.run_class;
                    n_att         = f.attached;
                end
            end
            HELD_TWO: begin
                grp.bytes[0]  = r_h0;
                grp.starts[0] = 1'b1;
                grp.bytes[1]  = r_h1;
                grp.bytes[2]  = b;
                if (b == want) begin
                    grp.cnt      = 2'd3;
                    n_held_count = HELD_NONE;
                    n_run        = CLS_NONE;
                end else begin
                    grp.starts[1] = 1'b1;
                    grp.starts[2] = f.start;
                    grp.cnt       = f.emit ? 2'd3 : 2'd2;
                    n_held_count  = f.hold ? HELD_ONE : HELD_NONE;
                    n_h0          = f.hold ? b : r_h0;
                    n_run         = f.run_class;
                    n_att         = f.attached;
                end
            end
            default: begin
                grp.bytes[0]  = b;
                grp.starts[0] = f.start;
                grp.cnt       = f.emit ? 2'd1 : 2'd0;
                n_held_count  = f.hold ? HELD_ONE : HELD_NONE;
                n_h0          = f.hold ? b : r_h0;
                n_run         = f.run_class;
                n_att         = f.attached;
            end
        endcase
        // Flush at end of text and return to text-start state
        if (last) begin
            grp.done     = 1'b1;
            n_held_count = HELD_NONE;
            n_run        = CLS_NONE;
            n_att        = 1'b0;
        end
    end

    assign o_group       = grp;
    assign o_group_valid = i_valid && (grp.cnt != 2'd0);

    // Advance run state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= HELD_NONE;
            r_run        <= CLS_NONE;
            r_att        <= 1'b0;
        end else if (i_valid) begin
            r_held_count <= n_held_count;
            r_run        <= n_run;
            r_att        <= n_att;
        end
    end

    // Held bytes carry no reset
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_h0 <= n_h0;
            r_h1 <= n_h1;
        end
    end

endmodule

// ===== hdl/atp_group_fifo.sv =====
// Short queue of byte groups between the front end and the serializer.
`timescale 1ns / 1ps

module atp_group_fifo
    import atp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_group i_wr_data,
    output logic   o_full,
    input  logic   i_rd,
    output t_group o_rd_data,
    output logic   o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_group        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign o_full    = (r_cnt == FULL_CNT);
    assign o_empty   = (r_cnt == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Store groups
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/atp_back.sv =====
// Back end: serializes byte groups into one result beat per cycle while pop is asserted.
`timescale 1ns / 1ps

module atp_back
    import atp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_group    i_group,
    input  logic      i_group_avail,
    output logic      o_group_take,
    input  logic      i_pop,
    output t_out_beat o_beat,
    output logic      o_empty
);

    t_group     r_cur;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       last_byte;
    logic       popped;

    assign last_byte    = (r_idx == (r_cur.cnt - 2'd1));
    assign popped       = r_valid && i_pop;
    assign o_group_take = i_group_avail && (!r_valid || (popped && last_byte));

    assign o_empty            = !r_valid;
    assign o_beat.out_byte    = r_cur.bytes[r_idx];
    assign o_beat.piece_start = r_cur.starts[r_idx];
    assign o_beat.text_done   = r_cur.done && last_byte;

    // Step through the current group, load the next when it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_group_take) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (popped) begin
            if (last_byte) begin
                r_valid <= 1'b0;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Group payload carries no reset
    always_ff @(posedge i_clk) begin
        if (o_group_take) begin
            r_cur <= i_group;
        end
    end

endmodule

// ===== hdl/ascii_text_pretokenizer_core.sv =====
// Top level of the streaming ASCII text pretokenizer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | push / full          | i_in_data  (in_byte, end_of_text)
//   result   | pop / empty          | o_out_data (out_byte, piece_start, text_done)
//
// One byte is accepted per cycle while the queue is not full; the front end
// resolves it in the same cycle and writes the bytes it releases (one to three)
// as one group to the queue. The serializer hands out one result beat per cycle
// while pop is asserted, so a group of three needs three pops; the group queue
// absorbs the burst while input keeps flowing. With queue and serializer idle, the
// first released beat passes the queue, then the serializer register, to the ports.
// Synchronous reset empties the queue and serializer and returns to text start.
// full follows the queue alone; a stalled result side stalls input only when
// the queue fills.
`timescale 1ns / 1ps

module ascii_text_pretokenizer_core
    import atp_pkg::*;
#(
    parameter int GROUP_QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_beat  i_in_data,
    input  logic      pop,
    output logic      empty,
    output t_out_beat o_out_data
);

    logic   in_accept;
    t_group front_group;
    logic   front_group_valid;
    t_group q_group;
    logic   q_empty;
    logic   q_take;

    assign in_accept = push && !full;

    atp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_accept),
        .i_beat        (i_in_data),
        .o_group       (front_group),
        .o_group_valid (front_group_valid)
    );

    atp_group_fifo #(
        .DEPTH (GROUP_QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_group_valid),
        .i_wr_data (front_group),
        .o_full    (full),
        .i_rd      (q_take),
        .o_rd_data (q_group),
        .o_empty   (q_empty)
    );

    atp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_group       (q_group),
        .i_group_avail (!q_empty),
        .o_group_take  (q_take),
        .i_pop         (pop),
        .o_beat        (o_out_data),
        .o_empty       (empty)
    );

endmodule

// ===== hdl/atp_checker.sv =====
// Port-level checker for the pretokenizer, bound to the top level.
`timescale 1ns / 1ps

module atp_checker
    import atp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input logic      full,
    input logic      pop,
    input logic      empty,
    input t_out_beat o_out_data
);

    // Leaving reset shows no result
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> empty)
        else $error("result shown right after reset");

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_data)))
        else $error("stalled result beat changed");

    // Produce nothing without input
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !(push && !full) && !$past(push && !full)) |=> empty)
        else $error("result appeared without an input beat");

endmodule

bind ascii_text_pretokenizer_core atp_checker u_atp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .o_out_data (o_out_data)
);
